>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the port checkers, sampled on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("port check failed");

// next-cycle implication
`define CHK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("port check failed");

`endif

>>> rtl/ftcs_pkg.sv
// ----------------------------------------------------------------------------
// ftcs_pkg
// Shared widths, register codes and controller/datapath interface types
// for the 1D heat-equation stencil.
// ----------------------------------------------------------------------------
package ftcs_pkg;

	// grid geometry
	localparam int MAX_INTERIOR = 62;
	localparam int GRID_DEPTH   = MAX_INTERIOR + 2;
	localparam int ADDR_W       = $clog2(GRID_DEPTH);

	// field widths
	localparam int TEMP_W    = 16;
	localparam int BETA_W    = 16;
	localparam int STEP_W    = 16;
	localparam int NPTS_W    = 6;
	localparam int CFG_IDX_W = 2;

	// arithmetic widths: beta*(a+c) is 17x17, centre*b is 18x16
	localparam int PROD_W = BETA_W + TEMP_W + 2;
	localparam int ACC_W  = PROD_W + 2;
	localparam int FRAC_W = 12;

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic [ADDR_W-1:0]        addr_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BETA  = 2'd0,
		CFG_NPTS  = 2'd1,
		CFG_STEPS = 2'd2
	} cfg_reg_t;

	// commands from controller to datapath
	typedef struct packed {
		logic  load_we;
		addr_t load_addr;
		logic  rd_step;
		addr_t rd_addr;
		logic  rd_zero;
		logic  rd_last;
		logic  swap;
		logic  out_load;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic busy;
		logic out_free;
	} stat_t;

endpackage

>>> rtl/ftcs_dp.sv
// ----------------------------------------------------------------------------
// ftcs_dp
// Grid memories (ping-pong banks), three-point stencil pipeline and
// result output register.
// ----------------------------------------------------------------------------
module ftcs_dp import ftcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic [BETA_W-1:0] beta,
	input  temp_t             initial_temp,
	input  logic              result_stall,
	output stat_t             stat,
	output logic              result_valid,
	output addr_t             point_index,
	output temp_t             temperature,
	output logic              last_point
);

	localparam logic [BETA_W+1:0] CENTRE_ONE = (BETA_W + 2)'(1 << FRAC_W);
	localparam logic signed [ACC_W-1:0] RND = ACC_W'(1 << (FRAC_W - 1));
	localparam int Q_W = ACC_W - FRAC_W;
	localparam logic signed [Q_W-1:0] SAT_HI = Q_W'((1 << (TEMP_W - 1)) - 1);
	localparam logic signed [Q_W-1:0] SAT_LO = -SAT_HI - Q_W'(1);

	temp_t bank0_mem [GRID_DEPTH];
	temp_t bank1_mem [GRID_DEPTH];
	logic  bank_q;

	temp_t rd0_s1, rd1_s1;
	logic  step_s1;
	logic  zero_s1, last_s1;
	addr_t idx_s1;
	temp_t d_s1;
	logic  calc_s1;

	temp_t w_prev_q, w_cur_q;
	logic signed [TEMP_W:0]   side_sum;
	logic signed [BETA_W:0]   beta_s;
	logic signed [BETA_W+1:0] centre;

	logic                     valid_s2;
	addr_t                    widx_s2;
	logic signed [PROD_W-1:0] side_s2, ctr_s2;
	logic signed [ACC_W-1:0]  acc_s2;
	logic signed [Q_W-1:0]    q_s2;
	temp_t                    sat_s2;

	logic  we0, we1;
	addr_t wa;
	temp_t wd;

	logic  result_valid_q;
	addr_t point_index_q;
	temp_t temperature_q;
	logic  last_q;

	// write port: load goes to the current bank, updates to the other one
	assign we0 = (cmd.load_we && !bank_q) || (valid_s2 && bank_q);
	assign we1 = (cmd.load_we && bank_q) || (valid_s2 && !bank_q);
	assign wa  = cmd.load_we ? cmd.load_addr : widx_s2;
	assign wd  = cmd.load_we ? initial_temp : sat_s2;

	// bank memories with registered read
	always_ff @(posedge clk) begin
		if (we0)
			bank0_mem[wa] <= wd;
		rd0_s1 <= bank0_mem[cmd.rd_addr];
	end

	always_ff @(posedge clk) begin
		if (we1)
			bank1_mem[wa] <= wd;
		rd1_s1 <= bank1_mem[cmd.rd_addr];
	end

	// bank select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
		end else if (cmd.swap) begin
			bank_q <= ~bank_q;
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1  <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			step_s1  <= cmd.rd_step;
			valid_s2 <= calc_s1;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= cmd.rd_zero;
		last_s1 <= cmd.rd_last;
		idx_s1  <= cmd.rd_addr;
	end

	// boundary points read as zero
	assign d_s1    = zero_s1 ? '0 : (bank_q ? rd1_s1 : rd0_s1);
	assign calc_s1 = step_s1 && (idx_s1 >= addr_t'(2));

	// sliding window over u[i-1], u[i]
	always_ff @(posedge clk) begin
		if (step_s1) begin
			w_prev_q <= (idx_s1 == addr_t'(1)) ? '0 : w_cur_q;
			w_cur_q  <= d_s1;
		end
	end

	// weights
	assign beta_s   = $signed({1'b0, beta});
	assign centre   = $signed(CENTRE_ONE - {1'b0, beta, 1'b0});
	assign side_sum = (TEMP_W + 1)'(w_prev_q) + (TEMP_W + 1)'(d_s1);

	// multiply stage
	always_ff @(posedge clk) begin
		side_s2 <= beta_s * side_sum;
		ctr_s2  <= centre * w_cur_q;
		widx_s2 <= idx_s1 - addr_t'(1);
	end

	// round half up, floor shift, saturate
	assign acc_s2 = ACC_W'(side_s2) + ACC_W'(ctr_s2) + RND;
	assign q_s2   = $signed(acc_s2[ACC_W-1:FRAC_W]);

	always_comb begin
		if (q_s2 > SAT_HI)
			sat_s2 = temp_t'(SAT_HI);
		else if (q_s2 < SAT_LO)
			sat_s2 = temp_t'(SAT_LO);
		else
			sat_s2 = q_s2[TEMP_W-1:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			point_index_q <= idx_s1;
			temperature_q <= d_s1;
			last_q        <= last_s1;
		end
	end

	assign stat.busy     = step_s1 || valid_s2;
	assign stat.out_free = !result_valid_q || !result_stall;

	assign result_valid = result_valid_q;
	assign point_index  = point_index_q;
	assign temperature  = temperature_q;
	assign last_point   = last_q;

endmodule

>>> rtl/ftcs_ctrl.sv
// ----------------------------------------------------------------------------
// ftcs_ctrl
// Sequencer: counts loaded points, walks the grid once per time step and
// then walks it once more to emit the results.
// ----------------------------------------------------------------------------
module ftcs_ctrl import ftcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [NPTS_W-1:0] interior_points,
	input  logic [STEP_W-1:0] time_steps,
	input  logic              item_valid,
	output logic              item_stall,
	input  stat_t             stat,
	output cmd_t              cmd
);

	typedef enum logic [4:0] {
		ST_LOAD    = 5'b00001,
		ST_STEP    = 5'b00010,
		ST_DRAIN   = 5'b00100,
		ST_EMIT_RD = 5'b01000,
		ST_EMIT_WR = 5'b10000
	} state_t;

	state_t state_q, state_d;
	addr_t  load_cnt_q, load_cnt_d;
	addr_t  addr_q, addr_d;
	logic [STEP_W-1:0] steps_q, steps_d;

	addr_t n_eff, n_last, lc_eff, lc_next;
	logic  accept;

	// point count clamped to the supported range
	always_comb begin
		if (interior_points == '0)
			n_eff = addr_t'(1);
		else if (ADDR_W'(interior_points) > addr_t'(MAX_INTERIOR))
			n_eff = addr_t'(MAX_INTERIOR);
		else
			n_eff = ADDR_W'(interior_points);
	end

	assign n_last  = n_eff + addr_t'(1);
	assign lc_eff  = (load_cnt_q >= n_eff) ? n_eff - addr_t'(1) : load_cnt_q;
	assign lc_next = lc_eff + addr_t'(1);

	assign item_stall = (state_q != ST_LOAD);
	assign accept     = item_valid && (state_q == ST_LOAD);

	// next state and commands
	always_comb begin
		state_d    = state_q;
		load_cnt_d = load_cnt_q;
		addr_d     = addr_q;
		steps_d    = steps_q;
		cmd        = '0;
		case (state_q)
			ST_LOAD: begin
				cmd.load_we   = accept;
				cmd.load_addr = lc_next;
				if (accept) begin
					if (lc_next == n_eff) begin
						load_cnt_d = '0;
						steps_d    = time_steps;
						if (time_steps == '0) begin
							addr_d  = '0;
							state_d = ST_EMIT_RD;
						end else begin
							addr_d  = addr_t'(1);
							state_d = ST_STEP;
						end
					end else begin
						load_cnt_d = lc_next;
					end
				end
			end
			ST_STEP: begin
				cmd.rd_step = 1'b1;
				cmd.rd_addr = addr_q;
				cmd.rd_zero = (addr_q == n_last);
				if (addr_q == n_last)
					state_d = ST_DRAIN;
				else
					addr_d = addr_q + addr_t'(1);
			end
			ST_DRAIN: begin
				if (!stat.busy) begin
					cmd.swap = 1'b1;
					steps_d  = steps_q - STEP_W'(1);
					if (steps_q == STEP_W'(1)) begin
						addr_d  = '0;
						state_d = ST_EMIT_RD;
					end else begin
						addr_d  = addr_t'(1);
						state_d = ST_STEP;
					end
				end
			end
			ST_EMIT_RD: begin
				cmd.rd_addr = addr_q;
				cmd.rd_zero = (addr_q == '0) || (addr_q == n_last);
				cmd.rd_last = (addr_q == n_last);
				if (stat.out_free)
					state_d = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				cmd.out_load = 1'b1;
				if (addr_q == n_last) begin
					state_d = ST_LOAD;
				end else begin
					addr_d  = addr_q + addr_t'(1);
					state_d = ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			load_cnt_q <= '0;
			addr_q     <= '0;
			steps_q    <= '0;
		end else begin
			state_q    <= state_d;
			load_cnt_q <= load_cnt_d;
			addr_q     <= addr_d;
			steps_q    <= steps_d;
		end
	end

endmodule

>>> rtl/ftcs_heat_stencil_1d.sv
// ----------------------------------------------------------------------------
// ftcs_heat_stencil_1d
// Explicit FTCS solver for the 1D heat equation, saturating Q1.14 grid.
//
// Usage: write beta_q12, interior_points and time_steps on the cfg channel
// (always ready) while the block is idle. Send n initial temperatures on the
// item channel, point 1 first. Each item is taken in the same cycle in which
// it is offered while item_stall is low. The item that completes the load
// starts a run of time_steps time steps: one grid point is read from the
// single-read-port grid bank per cycle, and the stencil pipeline drains
// before each new time step. The block then emits n + 2 results, points 0 to
// n + 1, with last_point set on the right boundary. item_stall is high from
// the completing item until the last result sits in the output register;
// result_stall holds the output register and pauses emission. Reset clears
// the load count and the configuration to its defaults; grid contents are
// not cleared and need no clearing.
// ----------------------------------------------------------------------------
module ftcs_heat_stencil_1d import ftcs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BETA_W-1:0]    cfg_data,
	// input items
	input  logic                 item_valid,
	output logic                 item_stall,
	input  temp_t                initial_temp,
	// results
	output logic                 result_valid,
	input  logic                 result_stall,
	output addr_t                point_index,
	output temp_t                temperature,
	output logic                 last_point
);

	logic [BETA_W-1:0] beta_q;
	logic [NPTS_W-1:0] npts_q;
	logic [STEP_W-1:0] steps_q;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q  <= BETA_W'(2048);
			npts_q  <= NPTS_W'(10);
			steps_q <= STEP_W'(50);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_BETA:  beta_q  <= cfg_data;
				CFG_NPTS:  npts_q  <= cfg_data[NPTS_W-1:0];
				CFG_STEPS: steps_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	ftcs_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.interior_points (npts_q),
		.time_steps      (steps_q),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.stat            (stat),
		.cmd             (cmd)
	);

	ftcs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.beta         (beta_q),
		.initial_temp (initial_temp),
		.result_stall (result_stall),
		.stat         (stat),
		.result_valid (result_valid),
		.point_index  (point_index),
		.temperature  (temperature),
		.last_point   (last_point)
	);

endmodule

>>> rtl/ftcs_checker.sv
// ----------------------------------------------------------------------------
// ftcs_checker
// Port-level checks on the stencil block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ftcs_checker import ftcs_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  item_stall,
	input logic  result_valid,
	input logic  result_stall,
	input addr_t point_index,
	input temp_t temperature,
	input logic  last_point
);

	// a stalled result holds its place
	`CHK_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(point_index))

	// and its payload
	`CHK_NEXT(a_data_hold, result_valid && result_stall, $stable(temperature) && $stable(last_point))

	// no new items while a run is still emitting
	`CHK_IMPLY(a_no_load_mid_emit, result_valid && !last_point, item_stall)

	// the right boundary is never before point 2
	`CHK_IMPLY(a_last_index, result_valid && last_point, point_index > addr_t'(1))

	// the left boundary is held at zero
	`CHK_IMPLY(a_left_zero, result_valid && (point_index == '0), temperature == '0)

endmodule

bind ftcs_heat_stencil_1d ftcs_checker u_ftcs_checker (.*);
